/* design/key_count_max_heap_defines.svh */
// assertion helpers for the key count heap
`ifndef KEY_COUNT_MAX_HEAP_DEFINES_SVH
`define KEY_COUNT_MAX_HEAP_DEFINES_SVH

// same-cycle implication
`define KCMH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KCMH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/kcmh_pkg.sv */
`default_nettype none

package kcmh_pkg;

  // heap geometry
  localparam int unsigned MAX_ENTRIES = 16;
  localparam int unsigned KEY_BITS    = 8;
  localparam int unsigned COUNT_BITS  = 16;
  localparam int unsigned ADDR_BITS   = $clog2(MAX_ENTRIES);
  localparam int unsigned FILL_BITS   = $clog2(MAX_ENTRIES + 1);

  // stream widths, rounded up to whole bytes
  localparam int unsigned IN_TDATA_W  = ((KEY_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((KEY_BITS + COUNT_BITS + FILL_BITS + 1 + 7) / 8) * 8;

  // one heap entry as stored in memory
  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [COUNT_BITS-1:0] count;
  } entry_t;

  // result beat, last field in the lowest bits
  typedef struct packed {
    logic                  dropped;
    logic [FILL_BITS-1:0]  entry_total;
    logic [COUNT_BITS-1:0] top_count;
    logic [KEY_BITS-1:0]   top_key;
  } result_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SIFT_RD,
    ST_SIFT_CMP,
    ST_TOP_RD,
    ST_FINISH
  } state_e;

endpackage

`default_nettype wire

/* design/kcmh_ram.sv */
`default_nettype none

module kcmh_ram #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = 4,
  parameter int unsigned DATA_W = 24
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds when idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* design/kcmh_ctrl.sv */
`default_nettype none

module kcmh_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [kcmh_pkg::KEY_BITS-1:0]    key_i,
  output logic                             ram_we_o,
  output logic [kcmh_pkg::ADDR_BITS-1:0]   ram_waddr_o,
  output kcmh_pkg::entry_t                 ram_wdata_o,
  output logic                             ram_re_o,
  output logic [kcmh_pkg::ADDR_BITS-1:0]   ram_raddr_o,
  input  kcmh_pkg::entry_t                 ram_rdata_i,
  output logic                             res_valid_o,
  output kcmh_pkg::result_t                res_o,
  input  logic                             res_ready_i
);

  import kcmh_pkg::*;

  state_e                state_q, state_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [FILL_BITS-1:0]  fill_q, fill_d;
  logic [FILL_BITS-1:0]  rd_idx_q, rd_idx_d;
  logic                  cmp_pend_q, cmp_pend_d;
  logic [ADDR_BITS-1:0]  cmp_idx_q, cmp_idx_d;
  logic [FILL_BITS-1:0]  pos_q, pos_d;
  entry_t                cur_q, cur_d;
  logic                  drop_q, drop_d;

  logic                  hit;
  logic                  more;
  logic                  has_room;
  logic                  parent_less;
  logic                  at_root;
  logic [FILL_BITS-1:0]  par_slot;
  logic [FILL_BITS-1:0]  par_addr_w;
  logic [FILL_BITS-1:0]  pos_addr_w;
  logic [COUNT_BITS-1:0] inc_count;

  // search and sift conditions
  assign hit         = cmp_pend_q && (ram_rdata_i.key == key_q);
  assign more        = rd_idx_q < fill_q;
  assign has_room    = fill_q < FILL_BITS'(MAX_ENTRIES);
  assign parent_less = ram_rdata_i.count < cur_q.count;
  assign at_root     = pos_q == FILL_BITS'(1);
  assign par_slot    = pos_q >> 1;
  assign par_addr_w  = par_slot - FILL_BITS'(1);
  assign pos_addr_w  = pos_q - FILL_BITS'(1);
  assign inc_count   = (ram_rdata_i.count == '1) ? ram_rdata_i.count
                                                 : ram_rdata_i.count + COUNT_BITS'(1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (hit) begin
          state_d = ST_SIFT_RD;
        end else if (more) begin
          state_d = ST_SEARCH;
        end else if (has_room) begin
          state_d = ST_SIFT_RD;
        end else begin
          state_d = ST_TOP_RD;
        end
      end
      ST_SIFT_RD: begin
        state_d = at_root ? ST_TOP_RD : ST_SIFT_CMP;
      end
      ST_SIFT_CMP: begin
        state_d = parent_less ? ST_SIFT_RD : ST_TOP_RD;
      end
      ST_TOP_RD: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (res_ready_i) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // datapath and memory access
  always_comb begin
    key_d       = key_q;
    fill_d      = fill_q;
    rd_idx_d    = rd_idx_q;
    cmp_pend_d  = cmp_pend_q;
    cmp_idx_d   = cmp_idx_q;
    pos_d       = pos_q;
    cur_d       = cur_q;
    drop_d      = drop_q;
    in_ready_o  = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = pos_addr_w[ADDR_BITS-1:0];
    ram_wdata_o = cur_q;
    ram_re_o    = 1'b0;
    ram_raddr_o = rd_idx_q[ADDR_BITS-1:0];
    res_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          key_d      = key_i;
          rd_idx_d   = '0;
          cmp_pend_d = 1'b0;
          drop_d     = 1'b0;
        end
      end
      ST_SEARCH: begin
        if (hit) begin
          pos_d       = FILL_BITS'(cmp_idx_q) + FILL_BITS'(1);
          cur_d.key   = key_q;
          cur_d.count = inc_count;
        end else if (more) begin
          ram_re_o   = 1'b1;
          cmp_pend_d = 1'b1;
          cmp_idx_d  = rd_idx_q[ADDR_BITS-1:0];
          rd_idx_d   = rd_idx_q + FILL_BITS'(1);
        end else if (has_room) begin
          fill_d      = fill_q + FILL_BITS'(1);
          pos_d       = fill_q + FILL_BITS'(1);
          cur_d.key   = key_q;
          cur_d.count = COUNT_BITS'(1);
        end else begin
          drop_d = 1'b1;
        end
      end
      ST_SIFT_RD: begin
        if (at_root) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = '0;
          ram_wdata_o = cur_q;
        end else begin
          ram_re_o    = 1'b1;
          ram_raddr_o = par_addr_w[ADDR_BITS-1:0];
        end
      end
      ST_SIFT_CMP: begin
        // parent moves down or the held entry settles here
        ram_we_o = 1'b1;
        if (parent_less) begin
          ram_wdata_o = ram_rdata_i;
          pos_d       = par_slot;
        end else begin
          ram_wdata_o = cur_q;
        end
      end
      ST_TOP_RD: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = '0;
      end
      ST_FINISH: begin
        res_valid_o = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // result from the root read
  always_comb begin
    res_o.top_key     = ram_rdata_i.key;
    res_o.top_count   = ram_rdata_i.count;
    res_o.entry_total = fill_q;
    res_o.dropped     = drop_q;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      fill_q     <= '0;
      cmp_pend_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      cmp_pend_q <= cmp_pend_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    rd_idx_q  <= rd_idx_d;
    cmp_idx_q <= cmp_idx_d;
    pos_q     <= pos_d;
    cur_q     <= cur_d;
    drop_q    <= drop_d;
  end

endmodule

`default_nettype wire

/* design/key_count_max_heap.sv */
// key_count_max_heap: counts key occurrences in a binary max-heap by count.
// s_axis carries one key per beat; m_axis returns one result beat for every
// key: root key, root count, number of distinct keys and a drop flag for a
// new key that found the heap full.
// Entries live in a single memory with one read and one write port and a
// registered read. Each key is scanned for slot by slot, then its entry is
// sifted toward the root, one level per parent read (ST_SIFT_RD) and
// compare-and-write (ST_SIFT_CMP); a dropped key skips the sift. Only one
// item is worked on at a time; s_axis_tready is high again once the result
// sits in the output register, so the block takes no new key before it is
// through with the last one.
// Reset empties the heap (fill level zero), no clearing pass of the memory
// is needed since only occupied slots are read.
// When m_axis_tready is low the result holds in the output register; the
// block takes and processes the next key, then waits until that register
// drains before it loads the following result.
`default_nettype none
`include "key_count_max_heap_defines.svh"

module key_count_max_heap (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [7:0] key_value
  input  logic [kcmh_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [7:0] top_key, [23:8] top_count, [28:24] entry_total, [29] dropped
  output logic [kcmh_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

  import kcmh_pkg::*;

  logic                 ram_we;
  logic [ADDR_BITS-1:0] ram_waddr;
  entry_t               ram_wdata;
  logic                 ram_re;
  logic [ADDR_BITS-1:0] ram_raddr;
  entry_t               ram_rdata;
  logic                 res_valid;
  logic                 res_ready;
  result_t              res;
  logic                 m_valid_q;
  result_t              m_data_q;
  logic                 total_ok;
  logic                 heap_full;
  logic                 s_beat;

  // heap storage
  kcmh_ram #(
    .DEPTH  (MAX_ENTRIES),
    .ADDR_W (ADDR_BITS),
    .DATA_W ($bits(entry_t))
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // search and sift sequencer
  kcmh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .key_i       (s_axis_tdata[KEY_BITS-1:0]),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  // output register
  assign res_ready = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      m_data_q <= res;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - $bits(result_t))'(0), m_data_q};

  // check terms
  assign total_ok  = (m_data_q.entry_total != '0) &&
                     (m_data_q.entry_total <= FILL_BITS'(MAX_ENTRIES));
  assign heap_full = m_data_q.entry_total == FILL_BITS'(MAX_ENTRIES);
  assign s_beat    = s_axis_tvalid && s_axis_tready;

  // checks
  `KCMH_ASSERT_IMP(a_total_range, m_valid_q, total_ok, "entry total out of range")
  `KCMH_ASSERT_IMP(a_drop_full, m_valid_q && m_data_q.dropped, heap_full, "drop on a heap not full")
  `KCMH_ASSERT_NXT(a_one_at_a_time, s_beat, !s_axis_tready, "key taken while one in flight")

endmodule

`default_nettype wire
